[rtl/chtd_pkg.sv]
// chtd_pkg: shared types and constants of the chained hash table core
`timescale 1ns / 1ps

package chtd_pkg;

  // fixed field widths
  localparam int KEY_W    = 32;
  localparam int BCOUNT_W = 11;
  localparam int BIDX_W   = 10;
  localparam int ECNT_W   = 14;

  localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 11'd1021;

  // defaults for the top level parameters
  localparam int DEF_NUM_BUCKETS  = 1024;
  localparam int DEF_BUCKET_DEPTH = 8;
  localparam int DEF_KEY_WIDTH    = 32;

  // operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_DONE   = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_ABSENT = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [1:0]        status;
    logic [BIDX_W-1:0] bucket_index;
    logic [ECNT_W-1:0] entry_count;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

[rtl/chained_hash_table_division_core.sv]
// chained_hash_table_division_core: key store with bucketed slots, division hash
//
// Items come in on in_valid/in_stall with a function code (insert, search,
// delete) and a key; each item gives exactly one result item on
// out_valid/out_stall with found flag, status, bucket index and entry count.
// The user is to write the bucket count register through cfg_we/cfg_data only
// while idle; the block itself does not enforce this. One item is worked on at a
// time: the key goes through the serial modulo unit, which gives the bucket
// address, then the bucket is scanned through the slot memory's read port (one
// slot a cycle, pipelined against its registered read; the unused function
// code skips the scan), then an update step loads the result, and the core
// returns to idle to take the next item.
// After reset the slot memory is cleared one slot a cycle, all
// NUM_BUCKETS*BUCKET_DEPTH slots (8192 at the defaults), while in_stall is
// high; configuration writes are taken during that time.
// The result sits in an output register: a new item is accepted while it
// waits, and the update of that item holds until the receiver takes the
// previous result.
`timescale 1ns / 1ps

module chained_hash_table_division_core
  import chtd_pkg::*;
#(
  parameter int NUM_BUCKETS  = DEF_NUM_BUCKETS,
  parameter int BUCKET_DEPTH = DEF_BUCKET_DEPTH,
  parameter int KEY_WIDTH    = DEF_KEY_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_t                out_data,
  input  logic                cfg_we,
  input  logic [BCOUNT_W-1:0] cfg_data
);

  localparam int KW          = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
  localparam int TOTAL_SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
  localparam int MOD_W       = $clog2(NUM_BUCKETS + 1);
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int SLOT_CW     = $clog2(BUCKET_DEPTH + 1);
  localparam int CNT_W       = $clog2(TOTAL_SLOTS + 1);
  localparam int WORD_W      = KW + 1;

  state_t state, state_next;

  logic [BCOUNT_W-1:0] bucket_count;
  logic [31:0]         mod32;
  logic [MOD_W-1:0]    modulus;

  logic                accept;
  logic                mod_done;
  logic [BKT_W-1:0]    mod_rem;

  logic [1:0]          func_r;
  logic [KW-1:0]       key_r;
  logic [BKT_W-1:0]    bucket_r;
  logic [ADDR_W-1:0]   base_r;
  logic [SLOT_CW-1:0]  rd_slot;
  logic                chk_pend;
  logic [SLOT_CW-1:0]  chk_slot;
  logic                hit;
  logic [SLOT_CW-1:0]  hit_slot;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [ADDR_W-1:0]   clr_addr;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [WORD_W-1:0]   mem_rdata;

  logic                slot_match;
  logic                out_free;
  logic                load_out;
  logic                found_next;
  logic [1:0]          status_next;

  // effective modulus: zero acts as one, above NUM_BUCKETS it saturates
  always_comb begin
    if (bucket_count == '0) begin
      mod32 = 32'd1;
    end else if (32'(bucket_count) > 32'(NUM_BUCKETS)) begin
      mod32 = 32'(NUM_BUCKETS);
    end else begin
      mod32 = 32'(bucket_count);
    end
    modulus = MOD_W'(mod32);
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  chtd_mod #(
    .DIVIDEND_W (KW),
    .MOD_W      (MOD_W),
    .REM_W      (BKT_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (in_data.key[KW-1:0]),
    .modulus   (modulus),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  chtd_ram #(
    .DEPTH (TOTAL_SLOTS),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // insert looks for a free slot, search and delete for a stored copy
  always_comb begin
    if (func_r == FUNC_INSERT) begin
      slot_match = !mem_rdata[KW];
    end else begin
      slot_match = mem_rdata[KW] && (mem_rdata[KW-1:0] == key_r);
    end
  end

  always_comb begin
    count_next  = count;
    found_next  = 1'b0;
    status_next = STATUS_DONE;
    case (func_r)
      FUNC_INSERT: begin
        if (hit) begin
          count_next = count + 1'b1;
        end else begin
          status_next = STATUS_FULL;
        end
      end
      FUNC_SEARCH: begin
        found_next = hit;
        if (!hit) begin
          status_next = STATUS_ABSENT;
        end
      end
      FUNC_DELETE: begin
        found_next = hit;
        if (hit) begin
          if (count != '0) begin
            count_next = count - 1'b1;
          end
        end else begin
          status_next = STATUS_ABSENT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = base_r + ADDR_W'(hit_slot);
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = base_r + ADDR_W'(rd_slot);
    load_out   = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == ADDR_W'(TOTAL_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          if (func_r inside {FUNC_INSERT, FUNC_SEARCH, FUNC_DELETE}) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_UPDATE;
          end
        end
      end
      ST_SCAN: begin
        mem_re = (rd_slot < SLOT_CW'(BUCKET_DEPTH));
        if (chk_pend) begin
          if (slot_match || chk_slot == SLOT_CW'(BUCKET_DEPTH - 1)) begin
            state_next = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
          if (hit && (func_r inside {FUNC_INSERT, FUNC_DELETE})) begin
            mem_we = 1'b1;
            if (func_r == FUNC_INSERT) begin
              mem_wdata = {1'b1, key_r};
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BCOUNT_RESET;
      count        <= '0;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
      chk_pend     <= 1'b0;
      rd_slot      <= '0;
      hit          <= 1'b0;
    end else begin
      if (cfg_we) begin
        bucket_count <= cfg_data;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        count     <= count_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_DIV) begin
        rd_slot  <= '0;
        chk_pend <= 1'b0;
        hit      <= 1'b0;
      end else if (state == ST_SCAN) begin
        chk_pend <= mem_re;
        if (mem_re) begin
          rd_slot <= rd_slot + 1'b1;
        end
        if (chk_pend && slot_match) begin
          hit <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_data.func;
      key_r  <= in_data.key[KW-1:0];
    end
    if (state == ST_DIV && mod_done) begin
      bucket_r <= mod_rem;
      base_r   <= ADDR_W'(mod_rem) * ADDR_W'(BUCKET_DEPTH);
    end
    if (state == ST_SCAN) begin
      chk_slot <= rd_slot;
      if (chk_pend && slot_match) begin
        hit_slot <= chk_slot;
      end
    end
    if (load_out) begin
      out_data.found        <= found_next;
      out_data.status       <= status_next;
      out_data.bucket_index <= BIDX_W'(bucket_r);
      out_data.entry_count  <= ECNT_W'(count_next);
    end
  end

endmodule

[rtl/chtd_mod.sv]
// chtd_mod: bit-serial restoring modulo of the key by the bucket count
`timescale 1ns / 1ps

module chtd_mod #(
  parameter int DIVIDEND_W = 32,
  parameter int MOD_W      = 11,
  parameter int REM_W      = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [MOD_W-1:0]      modulus,
  output logic                  done,
  output logic [REM_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] sh;
  logic [MOD_W-1:0]      rem;
  logic [MOD_W-1:0]      rem_next;
  logic [MOD_W:0]        trial;

  // trial stays below twice the modulus, so one subtract keeps rem below it
  always_comb begin
    trial = {rem, sh[DIVIDEND_W-1]};
    if (trial >= {1'b0, modulus}) begin
      rem_next = MOD_W'(trial - {1'b0, modulus});
    end else begin
      rem_next = trial[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      rem <= '0;
    end else if (busy) begin
      sh  <= {sh[DIVIDEND_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign remainder = REM_W'(rem);

endmodule

[rtl/chtd_ram.sv]
// chtd_ram: slot memory, one write and one registered read port
`timescale 1ns / 1ps

module chtd_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
